// ===== rtl/mpm_pkg.sv =====
// ---------------------------------------------------------------------------
// mpm_pkg: shared definitions for the multichannel PCM mixer
// Command codes, register indexes, mixing weights and field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package mpm_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_NUM_FX_CHANNELS = 3;
	localparam int DEF_LENGTH_BITS     = 24;

	// Fixed field widths of the item ports.
	localparam int KIND_W     = 3;
	localparam int CHAN_W     = 3;
	localparam int LEN_IN_W   = 24;
	localparam int SAMPLE_W   = 16;
	localparam int POS_OUT_W  = 24;
	localparam int MASK_W     = 4;
	localparam int LOADED_W   = 2;
	localparam int NUM_IN_SAMPLES = 4;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int GAIN_W     = 2;
	localparam int WEIGHT_W   = 16;

	// Mixing constants.
	localparam int ALLOC_MUSIC   = 200;
	localparam int ALLOC_FX      = 104;
	localparam int BASE_SHIFT    = 18;
	localparam int SHIFT_W       = 5;
	localparam int SAT_MAX       = 32767;
	localparam int SAT_MIN       = -32768;
	localparam int VOLUME_RESET  = 255;
	localparam int GAIN_RESET    = 1;

	// Channel code that asks for the first idle effect channel.
	localparam logic [CHAN_W-1:0] CHAN_AUTO = 3'd4;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK   = 3'd0,
		KIND_LOAD   = 3'd1,
		KIND_STOP   = 3'd2,
		KIND_PAUSE  = 3'd3,
		KIND_RESUME = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MUSIC_VOLUME  = 2'd0,
		CFG_EFFECT_VOLUME = 2'd1,
		CFG_GAIN_SELECT   = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/multichannel_pcm_mixer_unit.sv =====
// Order: a word is taken into the input register (s1), then processed and written into the result
// register. Throughput: one word per cycle unless the receiver stalls; every channel lane and the
// weighted sum work in the same cycle.
// Stalls: the input stalls only while both the input and the result register hold words and the
// receiver stalls. Reset: all channels inactive with zero length and position, volumes 255, gain 1.
// ---------------------------------------------------------------------------
// multichannel_pcm_mixer_unit: four-channel PCM mixer with saturation
// One music channel and NUM_FX_CHANNELS effect channels are played from
// per-channel length and position counters. Command words load, stop,
// pause or resume a channel; a tick word mixes one output sample.
// ---------------------------------------------------------------------------
`default_nettype none

module multichannel_pcm_mixer_unit
	import mpm_pkg::*;
#(
	parameter int NUM_FX_CHANNELS = DEF_NUM_FX_CHANNELS,
	parameter int LENGTH_BITS     = DEF_LENGTH_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,

	// Configuration write channel.
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_DATA_W-1:0]       cfg_data,

	// Input word channel.
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [KIND_W-1:0]           kind,
	input  wire logic [CHAN_W-1:0]           channel,
	input  wire logic [LEN_IN_W-1:0]         length_samples,
	input  wire logic                        repeat_req,
	input  wire logic signed [SAMPLE_W-1:0]  sample_music,
	input  wire logic signed [SAMPLE_W-1:0]  sample_fx1,
	input  wire logic signed [SAMPLE_W-1:0]  sample_fx2,
	input  wire logic signed [SAMPLE_W-1:0]  sample_fx3,

	// Result word channel.
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [SAMPLE_W-1:0]       mix_out,
	output logic [POS_OUT_W-1:0]             next_pos_music,
	output logic [POS_OUT_W-1:0]             next_pos_fx1,
	output logic [POS_OUT_W-1:0]             next_pos_fx2,
	output logic [POS_OUT_W-1:0]             next_pos_fx3,
	output logic [MASK_W-1:0]                active_mask,
	output logic [LOADED_W-1:0]              loaded_channel,
	output logic                             load_status
);

	// Channel 0 is music, channels 1..NUM_FX_CHANNELS are effects.
	localparam int NCH     = 1 + NUM_FX_CHANNELS;
	localparam int LB      = LENGTH_BITS;
	// Width that holds both the length counters and the 24-bit ports.
	localparam int WIDE_W  = (LB > LEN_IN_W) ? LB : LEN_IN_W;
	// One weighted term: unsigned 16-bit weight times a signed sample.
	localparam int PROD_W  = WEIGHT_W + SAMPLE_W + 1;
	localparam int SUM_W   = PROD_W + $clog2(NCH);

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SAT_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SAT_MIN);

	// -----------------------------------------------------------------------
	// Configuration. The volumes are kept already multiplied by their
	// allocation constant, so a tick needs only one multiply per channel.
	// Writes to an index past the register list are accepted and dropped.
	// -----------------------------------------------------------------------
	logic [WEIGHT_W-1:0] music_weight_q;
	logic [WEIGHT_W-1:0] fx_weight_q;
	logic [GAIN_W-1:0]   gain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			music_weight_q <= WEIGHT_W'(VOLUME_RESET * ALLOC_MUSIC);
			fx_weight_q    <= WEIGHT_W'(VOLUME_RESET * ALLOC_FX);
			gain_q         <= GAIN_W'(GAIN_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MUSIC_VOLUME:  music_weight_q <= WEIGHT_W'(cfg_data * ALLOC_MUSIC);
				CFG_EFFECT_VOLUME: fx_weight_q    <= WEIGHT_W'(cfg_data * ALLOC_FX);
				CFG_GAIN_SELECT:   gain_q         <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Handshake. The input register (s1) holds one word; it is processed and
	// written into the result register as soon as that register is free or
	// being drained, so a word can enter in every cycle while the receiver does not stall.
	// -----------------------------------------------------------------------
	logic s1_valid_q;
	logic s1_fire;

	assign s1_fire  = s1_valid_q && (!out_valid || !out_stall);
	assign in_stall = s1_valid_q && !s1_fire;

	logic [KIND_W-1:0]          kind_s1;
	logic [CHAN_W-1:0]          chan_s1;
	logic [LEN_IN_W-1:0]        len_s1;
	logic                       rep_s1;
	logic signed [SAMPLE_W-1:0] samp_s1 [NUM_IN_SAMPLES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1    <= kind;
			chan_s1    <= channel;
			len_s1     <= length_samples;
			rep_s1     <= repeat_req;
			samp_s1[0] <= sample_music;
			samp_s1[1] <= sample_fx1;
			samp_s1[2] <= sample_fx2;
			samp_s1[3] <= sample_fx3;
		end
	end

	// -----------------------------------------------------------------------
	// Channel decode. A direct code names an existing channel; the auto code
	// picks the lowest-numbered inactive effect channel.
	// -----------------------------------------------------------------------
	logic              direct_s1;
	logic              is_auto_s1;
	logic [LB-1:0]     load_len;
	logic [WIDE_W-1:0] load_len_wide;

	assign direct_s1     = (chan_s1 != CHAN_AUTO) && ({1'b0, chan_s1} < (CHAN_W + 1)'(NCH));
	assign is_auto_s1    = (chan_s1 == CHAN_AUTO);
	assign load_len_wide = WIDE_W'(len_s1);
	assign load_len      = load_len_wide[LB-1:0];

	logic [LB-1:0] pos_q  [NCH];
	logic [LB-1:0] len_q  [NCH];
	logic [NCH-1:0] act_q;
	logic [NCH-1:0] loop_q;

	logic [LB-1:0]  pos_d [NCH];
	logic [LB-1:0]  len_d [NCH];
	logic [NCH-1:0] act_d;
	logic [NCH-1:0] loop_d;

	logic [NCH-1:0] auto_sel;
	logic           auto_found;

	always_comb begin
		auto_sel   = '0;
		auto_found = 1'b0;
		for (int c = 1; c < NCH; c++) begin
			if (!act_q[c] && !auto_found) begin
				auto_sel[c] = 1'b1;
				auto_found  = 1'b1;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Channel lanes. Each lane updates its own length, position and flags
	// and hands its weighted sample term to the adder.
	// -----------------------------------------------------------------------
	logic signed [PROD_W-1:0] prod [NCH];
	logic [NCH-1:0]           load_sel;

	for (genvar c = 0; c < NCH; c++) begin : g_lane
		localparam logic [CHAN_W-1:0] CODE = CHAN_W'(c);

		logic                       hit;
		logic [LB-1:0]              pos_inc;
		logic                       at_end;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [SAMPLE_W-1:0] contrib;
		logic [WEIGHT_W-1:0]        weight;

		assign hit         = direct_s1 && (chan_s1 == CODE);
		assign load_sel[c] = hit || (is_auto_s1 && auto_sel[c]);

		// A position at or past the end restarts at zero when looping.
		assign pos_inc = ((pos_q[c] >= len_q[c]) ? '0 : pos_q[c]) + LB'(1);
		assign at_end  = (pos_inc >= len_q[c]) || (pos_inc == '0);

		if (c < NUM_IN_SAMPLES) begin : g_samp
			assign sample = samp_s1[c];
		end else begin : g_nosamp
			assign sample = '0;
		end

		if (c == 0) begin : g_wmus
			assign weight = music_weight_q;
		end else begin : g_wfx
			assign weight = fx_weight_q;
		end

		always_comb begin
			pos_d[c]  = pos_q[c];
			len_d[c]  = len_q[c];
			act_d[c]  = act_q[c];
			loop_d[c] = loop_q[c];
			contrib   = '0;
			case (kind_s1)
				KIND_TICK: begin
					if (act_q[c]) begin
						if (len_q[c] == '0) begin
							act_d[c] = 1'b0;
						end else if (pos_q[c] >= len_q[c] && !loop_q[c]) begin
							act_d[c] = 1'b0;
						end else begin
							contrib  = sample;
							pos_d[c] = pos_inc;
							if (at_end) begin
								if (loop_q[c]) begin
									pos_d[c] = '0;
								end else begin
									act_d[c] = 1'b0;
								end
							end
						end
					end
				end
				KIND_LOAD: begin
					if (load_sel[c]) begin
						pos_d[c]  = '0;
						len_d[c]  = load_len;
						loop_d[c] = rep_s1;
						act_d[c]  = 1'b1;
					end
				end
				KIND_STOP: begin
					if (hit) begin
						act_d[c] = 1'b0;
						len_d[c] = '0;
						pos_d[c] = '0;
					end
				end
				KIND_PAUSE: begin
					if (hit) begin
						act_d[c] = 1'b0;
					end
				end
				KIND_RESUME: begin
					if (hit && len_q[c] != '0) begin
						act_d[c] = 1'b1;
					end
				end
				default: ;
			endcase
		end

		assign prod[c] = PROD_W'($signed({1'b0, weight})) * PROD_W'(contrib);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pos_q[c]  <= '0;
				len_q[c]  <= '0;
				act_q[c]  <= 1'b0;
				loop_q[c] <= 1'b0;
			end else if (s1_fire) begin
				pos_q[c]  <= pos_d[c];
				len_q[c]  <= len_d[c];
				act_q[c]  <= act_d[c];
				loop_q[c] <= loop_d[c];
			end
		end
	end

	// -----------------------------------------------------------------------
	// Mix: sum of weighted terms, arithmetic shift by 18 minus the gain
	// select (a floor division), then saturation to 16 bits.
	// -----------------------------------------------------------------------
	logic signed [SUM_W-1:0] mix_sum;
	logic signed [SUM_W-1:0] mix_shifted;
	logic [SHIFT_W-1:0]      shamt;
	logic signed [SAMPLE_W-1:0] mix_sat;

	always_comb begin
		mix_sum = '0;
		for (int c = 0; c < NCH; c++) begin
			mix_sum = mix_sum + SUM_W'(prod[c]);
		end
	end

	assign shamt       = SHIFT_W'(BASE_SHIFT) - SHIFT_W'(gain_q);
	assign mix_shifted = mix_sum >>> shamt;

	always_comb begin
		if (mix_shifted > SAT_HI) begin
			mix_sat = SAMPLE_W'(SAT_MAX);
		end else if (mix_shifted < SAT_LO) begin
			mix_sat = SAMPLE_W'(SAT_MIN);
		end else begin
			mix_sat = mix_shifted[SAMPLE_W-1:0];
		end
	end

	// -----------------------------------------------------------------------
	// Load report: target channel number, or the no-idle-channel flag.
	// -----------------------------------------------------------------------
	logic [CHAN_W-1:0] load_idx;
	logic              load_full;

	always_comb begin
		load_idx = '0;
		for (int c = 0; c < NCH; c++) begin
			if (load_sel[c]) begin
				load_idx = load_idx | CHAN_W'(c);
			end
		end
	end

	assign load_full = (kind_s1 == KIND_LOAD) && is_auto_s1 && !auto_found;

	// Positions and active bits for the four reported channels.
	logic [POS_OUT_W-1:0] pos_rep [MASK_W];
	logic [MASK_W-1:0]    mask_rep;

	for (genvar k = 0; k < MASK_W; k++) begin : g_rep
		if (k < NCH) begin : g_have
			logic [WIDE_W-1:0] pos_wide;
			assign pos_wide    = WIDE_W'(pos_d[k]);
			assign pos_rep[k]  = pos_wide[POS_OUT_W-1:0];
			assign mask_rep[k] = act_d[k];
		end else begin : g_none
			assign pos_rep[k]  = '0;
			assign mask_rep[k] = 1'b0;
		end
	end

	// -----------------------------------------------------------------------
	// Result register. It is refilled whenever s1 fires and emptied when the
	// receiver takes the word.
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_fire) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			mix_out        <= (kind_s1 == KIND_TICK) ? mix_sat : '0;
			next_pos_music <= pos_rep[0];
			next_pos_fx1   <= pos_rep[1];
			next_pos_fx2   <= pos_rep[2];
			next_pos_fx3   <= pos_rep[3];
			active_mask    <= mask_rep;
			loaded_channel <= (kind_s1 == KIND_LOAD) ? load_idx[LOADED_W-1:0] : '0;
			load_status    <= load_full;
		end
	end

	// -----------------------------------------------------------------------
	// Assertions.
	// -----------------------------------------------------------------------
	logic [NCH-1:0] len_zero;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			len_zero[c] = (len_q[c] == '0);
		end
	end

	// After a tick no channel may stay active with a zero length.
	a_tick_clears_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && kind_s1 == KIND_TICK) |=> !(|(act_q & len_zero)))
		else $error("channel active with zero length after tick");

	// A word held in s1 is never overwritten before it is processed.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(kind_s1) && $stable(chan_s1)))
		else $error("input register lost a word");

	// A dropped auto load reports channel zero.
	a_full_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && load_status) |-> (loaded_channel == '0))
		else $error("dropped load reports a channel");

endmodule

`default_nettype wire
